// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, compiled out when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define BBL_ASSERT(lbl, prop, msg)
`define BBL_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/bbl_pkg.sv -----
package bbl_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 7;
  localparam int MAX_HEIGHT     = 4096;
  localparam int HW             = 13;
  localparam int CFG_W          = 13;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_ACC,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } pix_out_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quo;
  } div_status_t;

endpackage

// ----- hw/rtl/bbl_stream_if.sv -----
interface bbl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bbl_ram.sv -----
module bbl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hw/rtl/bbl_div.sv -----
module bbl_div #(
  parameter int NW = 18
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NW-1:0]         num_i,
  input  logic [NW-1:0]         den_i,
  output bbl_pkg::div_status_t  status_o
);
  import bbl_pkg::*;

  logic          busy_q;
  logic [2:0]    step_q;
  logic [NW-1:0] rem_q;
  logic [NW+6:0] dsh_q;
  logic [6:0]    quo_q;
  logic          fits;

  assign fits = (NW+7)'(rem_q) >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd7) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, 7'b0};
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q[NW-1:0];
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[5:0], fits};
    end
  end

  assign status_o.done = busy_q && (step_q == 3'd7);
  assign status_o.quo  = {quo_q, fits};
endmodule

// ----- hw/rtl/edge_clipped_box_blur.sv -----
// edge-clipped box blur over a raster rgb stream
// pix_in_i carries items of kind pixel or flush; pix_out_o carries blurred
// pixels with frame_last on the final one of the frame. both use valid/ready.
// configuration (width, height, radius) is written through cfg_we_i; the user
// must write it only while the block is idle; the block does not enforce this.
// any write to a listed register restarts the frame. an output pixel leaves
// once input pixel p + radius*width + radius is in; flush items drain the rest
// after the frame is complete, one per item. per emitted pixel the block runs
// a setup and a start step, then reads each covered window pixel (up to
// (2*radius+1)^2) through the single line store read port, drains the last
// read, divides each of the three channels in turn in the shared 8-step
// divider and then loads the output register. items that emit nothing leave
// the block idle. the block takes no item while it works on one.
// the result sits in an output register; a new item is taken while it waits,
// and the block only stalls at its output cycle if the register is still full.
// reset clears the frame position and sets width 1024, height 1024, radius 1;
// the line store is not cleared, only entries written in the frame are read.
`include "assert_macros.svh"
module edge_clipped_box_blur #(
  parameter int MAX_WIDTH  = bbl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = bbl_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  bbl_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [bbl_pkg::CFG_W-1:0]     cfg_data_i,
  bbl_stream_if.sink                    pix_in_i,
  bbl_stream_if.source                  pix_out_o
);
  import bbl_pkg::*;

  localparam int DEPTH   = (2*MAX_RADIUS+1)*(MAX_WIDTH+1);
  localparam int AW      = $clog2(DEPTH);
  localparam int WW      = $clog2(MAX_WIDTH+1);
  localparam int RW      = $clog2(MAX_RADIUS+1);
  localparam int LW      = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int NRW     = $clog2(2*MAX_RADIUS+2);
  localparam int CNT_MAX = (2*MAX_RADIUS+1)*(2*MAX_RADIUS+1);
  localparam int CW      = $clog2(CNT_MAX+1);
  localparam int SW      = $clog2(255*CNT_MAX+1);
  localparam int NW      = SW+2;

  state_e state_q, state_d;

  logic [10:0]   cfg_w_q;
  logic [HW-1:0] cfg_h_q;
  logic [2:0]    cfg_r_q;
  logic          cfg_dly_q;

  logic [WW-1:0] ew;
  logic [HW-1:0] eh;
  logic [RW-1:0] er;
  logic [LW-1:0] total_q, lag_q;

  logic [HW-1:0] in_row_q, out_row_q;
  logic [WW-1:0] in_col_q, out_col_q;
  logic [LW-1:0] in_lin_q, out_lin_q;
  logic [AW-1:0] wr_addr_q, out_addr_q;

  logic [RW+WW-1:0] prod_q;
  logic [RW-1:0]    dc_q;
  logic [NRW-1:0]   nrows_q, ncols_q, ri_q, ci_q;
  logic [AW-1:0]    addr_q, row_addr_q;
  logic             rd_v_q;
  logic [SW-1:0]    sum_q [3];
  logic [CW-1:0]    cnt_q;
  logic [1:0]       ch_q;
  logic [7:0]       res_q [3];

  pix_out_t    out_q;
  logic        out_valid_q;
  logic        accept, input_done, emit_pix, emit_flush;
  logic        out_load, out_last, div_start;
  logic [23:0] rd_data;
  div_status_t div_st;

  // effective configuration
  always_comb begin
    if (cfg_w_q == '0) begin
      ew = WW'(1);
    end else if (14'(cfg_w_q) > 14'(MAX_WIDTH)) begin
      ew = WW'(MAX_WIDTH);
    end else begin
      ew = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eh = HW'(1);
    end else if (cfg_h_q > HW'(MAX_HEIGHT)) begin
      eh = HW'(MAX_HEIGHT);
    end else begin
      eh = cfg_h_q;
    end
    if (6'(cfg_r_q) > 6'(MAX_RADIUS)) begin
      er = RW'(MAX_RADIUS);
    end else begin
      er = RW'(cfg_r_q);
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= LW'(ew) * LW'(eh);
    lag_q   <= LW'(er) * LW'(ew) + LW'(er);
  end

  assign pix_in_i.ready = (state_q == ST_IDLE) && !cfg_dly_q;
  assign accept         = pix_in_i.valid && pix_in_i.ready;
  assign input_done     = in_row_q >= eh;
  assign emit_pix       = (in_lin_q >= out_lin_q + lag_q) || (in_lin_q + LW'(1) == total_q);
  assign emit_flush     = input_done && (out_lin_q < total_q);
  assign out_load       = (state_q == ST_OUT) && (!out_valid_q || pix_out_o.ready);
  assign out_last       = (out_row_q == eh - HW'(1)) && (out_col_q == ew - WW'(1));
  assign div_start      = state_q == ST_DIV_INIT;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (pix_in_i.data.kind == KIND_PIXEL) begin
            if (!input_done && emit_pix) begin
              state_d = ST_SETUP;
            end
          end else if (emit_flush) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: state_d = ST_START;
      ST_START: state_d = ST_ACC;
      ST_ACC: begin
        if (ci_q == ncols_q - NRW'(1) && ri_q == nrows_q - NRW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_st.done) begin
          state_d = (ch_q == 2'd2) ? ST_OUT : ST_DIV_INIT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= 11'd1024;
      cfg_h_q    <= HW'(1024);
      cfg_r_q    <= 3'd1;
      cfg_dly_q  <= 1'b0;
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_lin_q   <= '0;
      wr_addr_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_lin_q  <= '0;
      out_addr_q <= '0;
    end else begin
      cfg_dly_q <= cfg_we_i;
      if (cfg_we_i && cfg_idx_i != REG_NONE) begin
        unique case (cfg_idx_i)
          REG_WIDTH:  cfg_w_q <= cfg_data_i[10:0];
          REG_HEIGHT: cfg_h_q <= cfg_data_i;
          REG_RADIUS: cfg_r_q <= cfg_data_i[2:0];
          default:    cfg_r_q <= cfg_r_q;
        endcase
        in_row_q   <= '0;
        in_col_q   <= '0;
        in_lin_q   <= '0;
        wr_addr_q  <= '0;
        out_row_q  <= '0;
        out_col_q  <= '0;
        out_lin_q  <= '0;
        out_addr_q <= '0;
      end else if (accept && pix_in_i.data.kind == KIND_PIXEL && !input_done) begin
        in_lin_q <= in_lin_q + LW'(1);
        if (in_col_q == ew - WW'(1)) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + HW'(1);
        end else begin
          in_col_q <= in_col_q + WW'(1);
        end
        if ((AW+1)'(wr_addr_q) + (AW+1)'(1) == (AW+1)'(DEPTH)) begin
          wr_addr_q <= '0;
        end else begin
          wr_addr_q <= wr_addr_q + AW'(1);
        end
      end else if (out_load) begin
        if (out_last) begin
          in_row_q   <= '0;
          in_col_q   <= '0;
          in_lin_q   <= '0;
          wr_addr_q  <= '0;
          out_row_q  <= '0;
          out_col_q  <= '0;
          out_lin_q  <= '0;
          out_addr_q <= '0;
        end else begin
          out_lin_q <= out_lin_q + LW'(1);
          if (out_col_q == ew - WW'(1)) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + HW'(1);
          end else begin
            out_col_q <= out_col_q + WW'(1);
          end
          if ((AW+1)'(out_addr_q) + (AW+1)'(1) == (AW+1)'(DEPTH)) begin
            out_addr_q <= '0;
          end else begin
            out_addr_q <= out_addr_q + AW'(1);
          end
        end
      end
    end
  end

  // window bounds
  logic [HW+RW-1:0] r_hi;
  logic [WW+RW-1:0] c_hi;
  logic [HW-1:0]    r2, r1;
  logic [WW-1:0]    c2, c1;
  logic [RW-1:0]    dr, dc;
  logic signed [AW+2:0] start_s;
  logic [AW+1:0]    row_next, col_next;

  always_comb begin
    dr   = (out_row_q >= HW'(er)) ? er : RW'(out_row_q);
    dc   = (WW+RW)'(out_col_q) >= (WW+RW)'(er) ? er : RW'(out_col_q);
    r_hi = (HW+RW)'(out_row_q) + (HW+RW)'(er);
    c_hi = (WW+RW)'(out_col_q) + (WW+RW)'(er);
    r2   = (r_hi < (HW+RW)'(eh - HW'(1))) ? HW'(r_hi) : eh - HW'(1);
    c2   = (c_hi < (WW+RW)'(ew - WW'(1))) ? WW'(c_hi) : ew - WW'(1);
    r1   = out_row_q - HW'(dr);
    c1   = out_col_q - WW'(dc);
    start_s  = (AW+3)'(out_addr_q) - (AW+3)'(prod_q) - (AW+3)'(dc_q);
    row_next = (AW+2)'(row_addr_q) + (AW+2)'(ew);
    col_next = (AW+2)'(addr_q) + (AW+2)'(1);
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_SETUP: begin
        prod_q  <= (RW+WW)'(dr) * (RW+WW)'(ew);
        dc_q    <= dc;
        nrows_q <= NRW'(r2 - r1) + NRW'(1);
        ncols_q <= NRW'(c2 - c1) + NRW'(1);
      end
      ST_START: begin
        if (start_s < 0) begin
          addr_q     <= AW'(start_s + (AW+3)'(DEPTH));
          row_addr_q <= AW'(start_s + (AW+3)'(DEPTH));
        end else begin
          addr_q     <= AW'(start_s);
          row_addr_q <= AW'(start_s);
        end
        ri_q <= '0;
        ci_q <= '0;
      end
      ST_ACC: begin
        if (ci_q == ncols_q - NRW'(1)) begin
          ci_q <= '0;
          ri_q <= ri_q + NRW'(1);
          if (row_next >= (AW+2)'(DEPTH)) begin
            row_addr_q <= AW'(row_next - (AW+2)'(DEPTH));
            addr_q     <= AW'(row_next - (AW+2)'(DEPTH));
          end else begin
            row_addr_q <= AW'(row_next);
            addr_q     <= AW'(row_next);
          end
        end else begin
          ci_q <= ci_q + NRW'(1);
          addr_q <= (col_next == (AW+2)'(DEPTH)) ? '0 : AW'(col_next);
        end
      end
      default: begin
        ri_q <= ri_q;
      end
    endcase
  end

  // accumulation of the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= state_q == ST_ACC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_START) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
      cnt_q    <= '0;
    end else if (rd_v_q) begin
      sum_q[0] <= sum_q[0] + SW'(rd_data[23:16]);
      sum_q[1] <= sum_q[1] + SW'(rd_data[15:8]);
      sum_q[2] <= sum_q[2] + SW'(rd_data[7:0]);
      cnt_q    <= cnt_q + CW'(1);
    end
  end

  bbl_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept && pix_in_i.data.kind == KIND_PIXEL && !input_done),
    .waddr_i (wr_addr_q),
    .wdata_i ({pix_in_i.data.red_in, pix_in_i.data.green_in, pix_in_i.data.blue_in}),
    .re_i    (state_q == ST_ACC),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // rounded mean, one channel at a time
  bbl_div #(
    .NW (NW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    ({sum_q[ch_q], 1'b0} + NW'(cnt_q)),
    .den_i    (NW'({cnt_q, 1'b0})),
    .status_o (div_st)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN) begin
      ch_q <= '0;
    end else if (state_q == ST_DIV_WAIT && div_st.done) begin
      res_q[ch_q] <= div_st.quo;
      if (ch_q != 2'd2) begin
        ch_q <= ch_q + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pix_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.red_out    <= res_q[0];
      out_q.green_out  <= res_q[1];
      out_q.blue_out   <= res_q[2];
      out_q.frame_last <= out_last;
    end
  end

  assign pix_out_o.valid = out_valid_q;
  assign pix_out_o.data  = out_q;

  `BBL_ASSERT(a_wr_addr_range, ({1'b0, wr_addr_q} < (AW+1)'(DEPTH)), "write address past store")
  `BBL_ASSERT_IMP(a_cnt_nonzero, state_q == ST_DIV_INIT, cnt_q != '0, "empty window at divide")
  `BBL_ASSERT_IMP(a_frame_restart, out_load && out_last, ##1 (in_lin_q == '0), "no restart")
endmodule

// ----- tb/sv/box_blur_checker.sv -----
`timescale 1ns / 100ps

module box_blur_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  bbl_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [bbl_pkg::CFG_W-1:0] cfg_data_i,
  bbl_stream_if                     pix_in_mon,
  bbl_stream_if                     pix_out_mon,
  output int                        fail_cnt_o,
  output int                        pending_o
);
  import bbl_pkg::*;

  localparam int STORE_DEPTH = (2 * MAX_RADIUS_DEF + 1) * (MAX_WIDTH_DEF + 1);

  logic [23:0]  pixel_store [STORE_DEPTH];
  logic [10:0]  width_q;
  logic [12:0]  height_q;
  logic [2:0]   radius_q;
  int unsigned  in_row, in_col, out_row, out_col;
  int           mismatches;
  pix_out_t     blurred_q [$];

  function automatic int unsigned used_width();
    if (width_q < 1) return 1;
    return (width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_q;
  endfunction

  function automatic int unsigned used_height();
    if (height_q < 1) return 1;
    return (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
  endfunction

  function automatic int unsigned used_radius();
    return (radius_q > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_q;
  endfunction

  function automatic logic [7:0] rounded_mean(int unsigned sum, int unsigned cnt);
    int unsigned v;
    v = (2 * sum + cnt) / (2 * cnt);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  // window mean of the next output pixel, then step the output position
  function automatic pix_out_t blur_next();
    int unsigned w, h, r, r1, r2, c1, c2, sr, sg, sb, cnt;
    logic [23:0] px;
    pix_out_t res;
    w = used_width();
    h = used_height();
    r = used_radius();
    r1 = (out_row >= r) ? out_row - r : 0;
    r2 = (out_row + r < h - 1) ? out_row + r : h - 1;
    c1 = (out_col >= r) ? out_col - r : 0;
    c2 = (out_col + r < w - 1) ? out_col + r : w - 1;
    sr = 0;
    sg = 0;
    sb = 0;
    cnt = 0;
    for (int unsigned x = r1; x <= r2; x++) begin
      for (int unsigned y = c1; y <= c2; y++) begin
        px = pixel_store[(x * w + y) % STORE_DEPTH];
        sr += px[23:16];
        sg += px[15:8];
        sb += px[7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    res.red_out    = rounded_mean(sr, cnt);
    res.green_out  = rounded_mean(sg, cnt);
    res.blue_out   = rounded_mean(sb, cnt);
    res.frame_last = (out_row == h - 1) && (out_col == w - 1);
    if (res.frame_last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return res;
  endfunction

  function automatic void take_item(pix_in_t it);
    int unsigned w, h, r, total, lag, received, out_lin;
    w = used_width();
    h = used_height();
    r = used_radius();
    total = w * h;
    lag = r * w + r;
    received = in_row * w + in_col;
    out_lin = out_row * w + out_col;
    if (it.kind == KIND_PIXEL) begin
      if (in_row >= h) return;
      pixel_store[received % STORE_DEPTH] = {it.red_in, it.green_in, it.blue_in};
      received++;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (received >= out_lin + lag + 1 || received == total)
        blurred_q.push_back(blur_next());
    end else if (in_row >= h && out_lin < total) begin
      blurred_q.push_back(blur_next());
    end
  endfunction

  function automatic void check_item(pix_out_t got);
    pix_out_t exp_px;
    if (blurred_q.size() == 0) begin
      $error("unexpected output item %h", got);
      mismatches++;
      return;
    end
    exp_px = blurred_q.pop_front();
    if (got.red_out !== exp_px.red_out) begin
      $error("red_out expected %0d actual %0d", exp_px.red_out, got.red_out);
      mismatches++;
    end
    if (got.green_out !== exp_px.green_out) begin
      $error("green_out expected %0d actual %0d", exp_px.green_out, got.green_out);
      mismatches++;
    end
    if (got.blue_out !== exp_px.blue_out) begin
      $error("blue_out expected %0d actual %0d", exp_px.blue_out, got.blue_out);
      mismatches++;
    end
    if (got.frame_last !== exp_px.frame_last) begin
      $error("frame_last expected %0d actual %0d", exp_px.frame_last, got.frame_last);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q = 11'd1024;
      height_q = 13'd1024;
      radius_q = 3'd1;
      restart_frame();
      blurred_q.delete();
      mismatches = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH: begin
            width_q = cfg_data_i[10:0];
            restart_frame();
          end
          REG_HEIGHT: begin
            height_q = cfg_data_i[12:0];
            restart_frame();
          end
          REG_RADIUS: begin
            radius_q = cfg_data_i[2:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (pix_in_mon.valid && pix_in_mon.ready) take_item(pix_in_mon.data);
      if (pix_out_mon.valid && pix_out_mon.ready) check_item(pix_out_mon.data);
      fail_cnt_o <= mismatches;
      pending_o <= blurred_q.size();
    end
  end

endmodule

// ----- tb/sv/edge_clipped_box_blur_test.sv -----
`timescale 1ns / 100ps

module edge_clipped_box_blur_test;
  import bbl_pkg::*;

  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int SETTLE_CYCLES = 400;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  int               fail_cnt;
  int               pending;
  int               idle_pct;
  int               stall_pct;
  int               cycles = 0;
  int               items_sent;

  bbl_stream_if #(.T(pix_in_t))  pix_in ();
  bbl_stream_if #(.T(pix_out_t)) pix_out ();

  edge_clipped_box_blur u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_in_i   (pix_in),
    .pix_out_o  (pix_out)
  );

  box_blur_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pix_in_mon  (pix_in),
    .pix_out_mon (pix_out),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // wait until every result is out and the block has finished its last item
  task automatic settle();
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_item(kind_e kind, logic [23:0] rgb);
    while ($urandom_range(99) < idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.data <= '{kind: kind, red_in: rgb[23:16], green_in: rgb[15:8],
                     blue_in: rgb[7:0]};
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned r);
    pix_in.valid <= 1'b0;
    settle();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_RADIUS, r);
  endtask

  function automatic logic [23:0] rand_pixel(bit extremes);
    if (extremes)
      return {{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
              {8{$urandom_range(1) == 1}}};
    return 24'($urandom_range(24'hffffff));
  endfunction

  // full frame: pixels, then the flush items that drain the lagging outputs
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned r,
                           bit noise, bit extremes, bit pause_mid);
    int unsigned ew, eh, total, lag, drain;
    ew = (w < 1) ? 1 : (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    eh = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    total = ew * eh;
    lag = r * ew + r;
    drain = (lag < total) ? lag : total - 1;
    configure(w, h, r);
    for (int unsigned k = 0; k < total; k++) begin
      if (noise && $urandom_range(19) == 0) send_item(KIND_FLUSH, rand_pixel(0));
      if (pause_mid && k == total / 2) begin
        pix_in.valid <= 1'b0;
        settle();
      end
      send_item(KIND_PIXEL, rand_pixel(extremes));
      items_sent++;
    end
    for (int unsigned k = 0; k < drain; k++) begin
      if (noise && $urandom_range(9) == 0) send_item(KIND_PIXEL, rand_pixel(0));
      send_item(KIND_FLUSH, rand_pixel(0));
      items_sent++;
    end
    if (noise) send_item(KIND_FLUSH, rand_pixel(0));
  endtask

  initial begin
    int unsigned fr;
    rst_ni = 1'b0;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    cfg_we = 1'b0;
    cfg_idx = REG_WIDTH;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_frame(3, 3, 1, 1, 1, 0);
    run_frame(0, 1, 0, 0, 1, 0);
    run_frame(5, 4, 7, 1, 1, 1);
    run_frame(3, 0, 2, 1, 1, 0);

    // unlisted index must not restart the frame
    configure(6, 6, 2);
    for (int k = 0; k < 10; k++) send_item(KIND_PIXEL, rand_pixel(1));
    pix_in.valid <= 1'b0;
    settle();
    cfg_write(REG_NONE, 13'h1fff);
    for (int k = 0; k < 26; k++) send_item(KIND_PIXEL, rand_pixel(0));
    for (int k = 0; k < 14; k++) send_item(KIND_FLUSH, rand_pixel(0));

    // frame cut short by a register write
    configure(4, 4, 1);
    for (int k = 0; k < 5; k++) send_item(KIND_PIXEL, rand_pixel(0));

    fr = 0;
    while (items_sent < 1000) begin
      case (fr % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if ($urandom_range(9) == 0)
        run_frame($urandom_range(64, 1), $urandom_range(4, 1), $urandom_range(7),
                  1'($urandom_range(1)), 0, 1'($urandom_range(1)));
      else
        run_frame($urandom_range(20, 1), $urandom_range(10, 1), $urandom_range(7),
                  1'($urandom_range(1)), $urandom_range(3) == 0, 0);
      fr++;
    end

    pix_in.valid <= 1'b0;
    settle();
    if (fail_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
